// ===== rtl/trial_division_prime_filter_unit_defines.svh =====
// Assertion macros shared by the prime filter checker.
`ifndef TRIAL_DIVISION_PRIME_FILTER_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDPF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tdpf_pkg.sv =====
// Types and constants shared by the trial-division prime filter.
`default_nettype none

package tdpf_pkg;

    localparam int VALUE_WIDTH = 32;
    // Widest odd divisor: rounded-up root of a positive value.
    localparam int ROOT_WIDTH = VALUE_WIDTH / 2 + 1;
    // Bit index into the candidate for the shift-subtract remainder.
    localparam int IDX_WIDTH = $clog2(VALUE_WIDTH);
    // Highest even bit position that a positive value can reach.
    localparam int SQRT_TOP_BIT = ((VALUE_WIDTH - 2) / 2) * 2;
    // Smallest divisor tried, and the one value kept untested.
    localparam int SMALLEST_ODD_PRIME = 3;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] candidate;
        logic                          last_in;
    } tdpf_in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] kept_value;
        logic                          is_prime;
        logic                          last_out;
    } tdpf_out_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture a new candidate, arm the root
        logic sqrt_step;  // one root digit
        logic root_load;  // round root to odd, arm the first remainder
        logic div_step;   // one remainder bit
        logic next_div;   // step divisor down by two, rearm remainder
        logic out_load;   // fill the output register
        logic out_prime;  // verdict for out_load
    } tdpf_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic reject;     // negative, even or below three
        logic is_three;
        logic sqrt_done;
        logic div_last;   // remainder step on bit zero
        logic rem_zero;
        logic div_three;  // divisor has reached three
    } tdpf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/trial_division_prime_filter_unit.sv =====
// Top level of the trial-division prime filter.
//
// Input channel: in_valid/in_ready carry one beat of in_data (candidate, last_in).
// Output channel: out_valid/out_ready carry one beat of out_data (kept_value,
// is_prime, last_out) for every input beat, in order. kept_value is the
// candidate when it is an odd prime and zero otherwise; 2 is not kept.
// One candidate is worked at a time; in_ready is high only while idle, and
// the next input beat can be taken in the same cycle that output valid rises.
// Path from input beat to output valid:
//   negative, even, below three or equal to three: classified, then handed off;
//   otherwise classified, then the root, then the odd divisors are tried (root
//   rounded up to odd, down to 3, stopping early on a zero remainder), then handed
//   off. Each divisor costs VALUE_WIDTH-1 shift-subtract steps of the remainder
//   unit plus one check; for 31-bit values the worst case is near 23000 divisors.
// A finished result sits in the output register, so the next candidate is
// accepted while it waits; a stalled receiver holds the following result in
// the controller until the register frees.
// Reset clears the controller and output valid; the datapath registers are not reset.
`default_nettype none

module trial_division_prime_filter_unit
    import tdpf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire tdpf_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output tdpf_out_t     out_data
);

    tdpf_cmd_t  cmd;
    tdpf_stat_t stat;

    tdpf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tdpf_datapath u_dp (
        .clk      (clk),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/tdpf_datapath.sv =====
// Datapath: candidate hold, digit-serial root, shift-subtract remainder, output register.
`default_nettype none

module tdpf_datapath
    import tdpf_pkg::*;
(
    input  wire logic       clk,
    input  wire tdpf_in_t   in_data,
    input  wire tdpf_cmd_t  cmd,
    output tdpf_stat_t      stat,
    output tdpf_out_t       out_data
);

    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic                   last_reg, last_next;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] r_reg, r_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [ROOT_WIDTH-1:0]  div_reg, div_next;
    logic [ROOT_WIDTH-1:0]  rem_reg, rem_next;
    logic [IDX_WIDTH-1:0]   idx_reg, idx_next;
    tdpf_out_t              out_reg, out_next;

    logic [VALUE_WIDTH-1:0] trial_sum;
    logic [ROOT_WIDTH:0]    rem_shift;
    logic [ROOT_WIDTH:0]    rem_diff;

    // Form one root digit and one remainder bit
    always_comb
    begin
        trial_sum = r_reg + b_reg;
        rem_shift = {rem_reg, value_reg[idx_reg]};
        rem_diff  = rem_shift - {1'b0, div_reg};
    end

    // Advance the datapath registers on controller commands
    always_comb
    begin
        value_next = value_reg;
        last_next  = last_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        out_next   = out_reg;

        if (cmd.load)
        begin
            value_next = VALUE_WIDTH'(in_data.candidate);
            last_next  = in_data.last_in;
            x_next     = VALUE_WIDTH'(in_data.candidate);
            r_next     = '0;
            b_next     = VALUE_WIDTH'(1) << SQRT_TOP_BIT;
        end

        if (cmd.sqrt_step)
        begin
            if (x_reg >= trial_sum)
            begin
                x_next = x_reg - trial_sum;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
        end

        if (cmd.root_load)
        begin
            div_next = r_reg[ROOT_WIDTH-1:0] | ROOT_WIDTH'(1);
            rem_next = '0;
            idx_next = IDX_WIDTH'(VALUE_WIDTH - 2);
        end

        if (cmd.next_div)
        begin
            div_next = div_reg - ROOT_WIDTH'(2);
            rem_next = '0;
            idx_next = IDX_WIDTH'(VALUE_WIDTH - 2);
        end

        if (cmd.div_step)
        begin
            if (!rem_diff[ROOT_WIDTH])
                rem_next = rem_diff[ROOT_WIDTH-1:0];
            else
                rem_next = rem_shift[ROOT_WIDTH-1:0];
            idx_next = idx_reg - IDX_WIDTH'(1);
        end

        if (cmd.out_load)
        begin
            out_next.kept_value = cmd.out_prime ? value_reg : '0;
            out_next.is_prime   = cmd.out_prime;
            out_next.last_out   = last_reg;
        end
    end

    // Hold payload state; no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
        x_reg     <= x_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
    end

    // Report status to the controller
    always_comb
    begin
        stat.reject    = value_reg[VALUE_WIDTH-1] || !value_reg[0]
                         || (value_reg < VALUE_WIDTH'(SMALLEST_ODD_PRIME));
        stat.is_three  = (value_reg == VALUE_WIDTH'(SMALLEST_ODD_PRIME));
        stat.sqrt_done = (b_reg == '0);
        stat.div_last  = (idx_reg == '0);
        stat.rem_zero  = (rem_reg == '0);
        stat.div_three = (div_reg == ROOT_WIDTH'(SMALLEST_ODD_PRIME));
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ===== rtl/tdpf_controller.sv =====
// Controller: sequences classify, root, trial divisions and result hand-off.
`default_nettype none

module tdpf_controller
    import tdpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire tdpf_stat_t stat,
    output tdpf_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASSIFY,
        S_SQRT,
        S_DIV,
        S_CHECK,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Output slot frees when empty or being taken this cycle
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                priority if (stat.reject)
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (stat.is_three)
                begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.root_load = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (stat.rem_zero)
                begin
                    verdict_next = 1'b0;
                    state_next   = S_DONE;
                end
                else if (stat.div_three)
                begin
                    verdict_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.next_div = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cmd.out_prime = verdict_reg;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            verdict_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            verdict_reg   <= verdict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/tdpf_checker.sv =====
// Port-level checker for the prime filter, bound to the top level.
`default_nettype none
`include "trial_division_prime_filter_unit_defines.svh"

module tdpf_checker
    import tdpf_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire tdpf_in_t  in_data,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire tdpf_out_t out_data
);

    logic kept_nonzero;
    logic kept_odd_positive;

    assign kept_nonzero      = (out_data.kept_value != '0);
    assign kept_odd_positive = !out_data.kept_value[VALUE_WIDTH-1] && out_data.kept_value[0];

    // Stalled input beat holds
    `TDPF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(in_data), "input beat changed while stalled")

    // Stalled result beat holds
    `TDPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "output beat changed while stalled")

    // Verdict flag agrees with the kept value
    `TDPF_ASSERT_NOW(a_flag_match, clk, rst_n, out_valid,
        out_data.is_prime == kept_nonzero, "is_prime disagrees with kept_value")

    // Kept values are positive and odd
    `TDPF_ASSERT_NOW(a_kept_odd, clk, rst_n, out_valid && out_data.is_prime,
        kept_odd_positive, "kept value is not a positive odd number")

    // One candidate at a time: busy right after an input beat
    `TDPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready,
        !in_ready, "input taken while a candidate is in work")

endmodule

bind trial_division_prime_filter_unit tdpf_checker u_tdpf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
